// ===== sv/spfa_pkg.sv =====
package spfa_pkg;

    localparam int MAX_NODES = 64;
    localparam int MAX_EDGES = 256;
    localparam int NODE_AW   = $clog2(MAX_NODES);
    localparam int EDGE_AW   = $clog2(MAX_EDGES);
    localparam int LINK_W    = EDGE_AW + 1;
    localparam int DIST_W    = 32;
    localparam int CNT_W     = 7;
    localparam int COST_W    = 16;
    localparam int FILL_W    = NODE_AW + 1;

    localparam logic [DIST_W-1:0] INF_DIST = 32'h3f3f3f3f;
    localparam logic [LINK_W-1:0] NIL_LINK = LINK_W'(MAX_EDGES);

    localparam logic [1:0] ACT_CLEAR  = 2'd0;
    localparam logic [1:0] ACT_ADD    = 2'd1;
    localparam logic [1:0] ACT_SOLVE  = 2'd2;
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    localparam logic CFG_NODE_COUNT  = 1'b0;
    localparam logic CFG_CYCLE_LIMIT = 1'b1;

    typedef struct packed {
        logic [DIST_W-1:0] best;
        logic [CNT_W-1:0]  cnt;
        logic              mark;
    } node_rec_t;

    typedef struct packed {
        logic [NODE_AW-1:0] target;
        logic [COST_W-1:0]  cost;
        logic [LINK_W-1:0]  link;
    } edge_rec_t;

    localparam int NODE_W = $bits(node_rec_t);
    localparam int EDGE_W = $bits(edge_rec_t);

endpackage

// ===== sv/spfa_ram.sv =====
module spfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/spfa_shortest_path_neg_cycle_core.sv =====
// clear and add edge each give no result
// solve: each queue pop and each edge relaxed waits on a registered read from the
// node, edge and queue memories, then one result per reported vertex
// a negative cycle gives one result as soon as an enqueue count reaches the limit
// aresetn (synchronous, active low) empties the graph, sets node_count 64 and
// cycle_limit 63; edge memory holds no reset and needs no clearing pass
module spfa_shortest_path_neg_cycle_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // edge_from[5:0], edge_to[11:6], edge_weight[27:12], source[33:28], zero pad
    input  logic [39:0] s_tdata,
    // action[1:0]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // vertex[5:0], distance[37:6], unreachable[38], negative_cycle[39]
    output logic [39:0] m_tdata,
    output logic        m_tlast,
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [6:0]  cfg_wdata
);

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_ADD_WR  = 4'd1;
    localparam logic [3:0] ST_POP     = 4'd2;
    localparam logic [3:0] ST_POP_W   = 4'd3;
    localparam logic [3:0] ST_U_RD    = 4'd4;
    localparam logic [3:0] ST_EDGE    = 4'd5;
    localparam logic [3:0] ST_EDGE_W  = 4'd6;
    localparam logic [3:0] ST_RELAX   = 4'd7;
    localparam logic [3:0] ST_NEG     = 4'd8;
    localparam logic [3:0] ST_EMIT_RD = 4'd9;
    localparam logic [3:0] ST_EMIT_LD = 4'd10;

    localparam int NA = spfa_pkg::NODE_AW;
    localparam int EA = spfa_pkg::EDGE_AW;
    localparam int LW = spfa_pkg::LINK_W;
    localparam int DW = spfa_pkg::DIST_W;
    localparam int CW = spfa_pkg::CNT_W;
    localparam int FW = spfa_pkg::FILL_W;
    localparam int MN = spfa_pkg::MAX_NODES;

    logic [3:0] state_reg, state_next;
    logic [MN-1:0] head_valid_reg, head_valid_next;
    logic [MN-1:0] node_valid_reg, node_valid_next;
    logic [LW-1:0] edges_used_reg, edges_used_next;
    logic [CW-1:0] node_count_reg, node_count_next;
    logic [CW-1:0] cycle_limit_reg, cycle_limit_next;
    logic [NA-1:0] from_reg, from_next;
    logic [NA-1:0] to_reg, to_next;
    logic [spfa_pkg::COST_W-1:0] cost_reg, cost_next;
    logic [NA-1:0] u_reg, u_next;
    logic [NA-1:0] v_reg, v_next;
    logic [DW-1:0] dist_u_reg, dist_u_next;
    logic [DW-1:0] cand_reg, cand_next;
    logic [LW-1:0] e_reg, e_next;
    logic [NA-1:0] rd_reg, rd_next;
    logic [NA-1:0] wr_reg, wr_next;
    logic [FW-1:0] fill_reg, fill_next;
    logic [CW-1:0] i_reg, i_next;
    logic          m_valid_reg, m_valid_next;
    logic [39:0]   m_data_reg, m_data_next;
    logic          m_last_reg, m_last_next;

    logic                      head_we, head_re;
    logic [NA-1:0]             head_waddr, head_raddr;
    logic [LW-1:0]             head_wdata, head_rdata;
    logic                      edge_we, edge_re;
    logic [EA-1:0]             edge_waddr, edge_raddr;
    spfa_pkg::edge_rec_t       edge_wdata, edge_rdata;
    logic                      node_we, node_re;
    logic [NA-1:0]             node_waddr, node_raddr;
    spfa_pkg::node_rec_t       node_wdata, node_rdata;
    logic                      fifo_we, fifo_re;
    logic [NA-1:0]             fifo_waddr, fifo_raddr;
    logic [NA-1:0]             fifo_wdata, fifo_rdata;

    spfa_ram #(.WIDTH(LW), .DEPTH(MN)) u_head_ram (
        .aclk(aclk), .we(head_we), .waddr(head_waddr), .wdata(head_wdata),
        .re(head_re), .raddr(head_raddr), .rdata(head_rdata)
    );

    spfa_ram #(.WIDTH(spfa_pkg::EDGE_W), .DEPTH(spfa_pkg::MAX_EDGES)) u_edge_ram (
        .aclk(aclk), .we(edge_we), .waddr(edge_waddr), .wdata(edge_wdata),
        .re(edge_re), .raddr(edge_raddr), .rdata(edge_rdata)
    );

    spfa_ram #(.WIDTH(spfa_pkg::NODE_W), .DEPTH(MN)) u_node_ram (
        .aclk(aclk), .we(node_we), .waddr(node_waddr), .wdata(node_wdata),
        .re(node_re), .raddr(node_raddr), .rdata(node_rdata)
    );

    spfa_ram #(.WIDTH(NA), .DEPTH(MN)) u_fifo_ram (
        .aclk(aclk), .we(fifo_we), .waddr(fifo_waddr), .wdata(fifo_wdata),
        .re(fifo_re), .raddr(fifo_raddr), .rdata(fifo_rdata)
    );

    logic [1:0]          in_action;
    logic [NA-1:0]       in_from, in_to, in_source;
    logic [spfa_pkg::COST_W-1:0] in_weight;
    logic                out_free;
    logic [CW-1:0]       last_index;
    spfa_pkg::node_rec_t rec_v;
    logic [CW-1:0]       cnt_new;

    assign in_action = s_tuser;
    assign in_from   = s_tdata[5:0];
    assign in_to     = s_tdata[11:6];
    assign in_weight = s_tdata[27:12];
    assign in_source = s_tdata[33:28];
    assign out_free  = !m_valid_reg || m_tready;

    // reported vertex range: zero counts as one, saturate at store size
    always_comb begin
        if (node_count_reg == '0) begin
            last_index = '0;
        end else if (node_count_reg > CW'(MN)) begin
            last_index = CW'(MN - 1);
        end else begin
            last_index = node_count_reg - 1'b1;
        end
    end

    // a record never written since the solve began reads as infinity
    always_comb begin
        if (node_valid_reg[v_reg]) begin
            rec_v = node_rdata;
        end else begin
            rec_v = '{best: spfa_pkg::INF_DIST, cnt: '0, mark: 1'b0};
        end
    end
    assign cnt_new = rec_v.cnt + 1'b1;

    always_comb begin
        state_next       = state_reg;
        head_valid_next  = head_valid_reg;
        node_valid_next  = node_valid_reg;
        edges_used_next  = edges_used_reg;
        node_count_next  = node_count_reg;
        cycle_limit_next = cycle_limit_reg;
        from_next        = from_reg;
        to_next          = to_reg;
        cost_next        = cost_reg;
        u_next           = u_reg;
        v_next           = v_reg;
        dist_u_next      = dist_u_reg;
        cand_next        = cand_reg;
        e_next           = e_reg;
        rd_next          = rd_reg;
        wr_next          = wr_reg;
        fill_next        = fill_reg;
        i_next           = i_reg;
        m_valid_next     = m_valid_reg && !m_tready;
        m_data_next      = m_data_reg;
        m_last_next      = m_last_reg;

        head_we = 1'b0; head_waddr = from_reg; head_wdata = edges_used_reg;
        head_re = 1'b0; head_raddr = in_from;
        edge_we = 1'b0; edge_waddr = edges_used_reg[EA-1:0];
        edge_wdata = '{target: to_reg, cost: cost_reg, link: spfa_pkg::NIL_LINK};
        edge_re = 1'b0; edge_raddr = e_reg[EA-1:0];
        node_we = 1'b0; node_waddr = v_reg;
        node_wdata = '{best: cand_reg, cnt: rec_v.cnt, mark: 1'b1};
        node_re = 1'b0; node_raddr = i_reg[NA-1:0];
        fifo_we = 1'b0; fifo_waddr = wr_reg; fifo_wdata = v_reg;
        fifo_re = 1'b0; fifo_raddr = rd_reg;

        if (cfg_we) begin
            unique case (cfg_addr)
                spfa_pkg::CFG_NODE_COUNT:  node_count_next  = cfg_wdata;
                spfa_pkg::CFG_CYCLE_LIMIT: cycle_limit_next = cfg_wdata;
                default: ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    unique case (in_action)
                        spfa_pkg::ACT_CLEAR: begin
                            head_valid_next = '0;
                            edges_used_next = '0;
                        end
                        spfa_pkg::ACT_ADD: begin
                            // a full store drops the edge
                            if (edges_used_reg < LW'(spfa_pkg::MAX_EDGES)) begin
                                head_re    = 1'b1;
                                from_next  = in_from;
                                to_next    = in_to;
                                cost_next  = in_weight;
                                state_next = ST_ADD_WR;
                            end
                        end
                        spfa_pkg::ACT_SOLVE: begin
                            node_valid_next            = '0;
                            node_valid_next[in_source] = 1'b1;
                            node_we    = 1'b1;
                            node_waddr = in_source;
                            node_wdata = '{best: '0, cnt: CW'(1), mark: 1'b1};
                            fifo_we    = 1'b1;
                            fifo_waddr = '0;
                            fifo_wdata = in_source;
                            rd_next    = '0;
                            wr_next    = NA'(1);
                            fill_next  = FW'(1);
                            state_next = ST_POP;
                        end
                        default: ;
                    endcase
                end
            end
            ST_ADD_WR: begin
                edge_we = 1'b1;
                edge_wdata.link = head_valid_reg[from_reg] ? head_rdata
                                                           : spfa_pkg::NIL_LINK;
                head_we = 1'b1;
                head_valid_next[from_reg] = 1'b1;
                edges_used_next = edges_used_reg + 1'b1;
                state_next = ST_IDLE;
            end
            ST_POP: begin
                if (fill_reg == '0) begin
                    i_next     = '0;
                    state_next = ST_EMIT_RD;
                end else begin
                    fifo_re    = 1'b1;
                    rd_next    = rd_reg + 1'b1;
                    fill_next  = fill_reg - 1'b1;
                    state_next = ST_POP_W;
                end
            end
            ST_POP_W: begin
                u_next     = fifo_rdata;
                node_re    = 1'b1;
                node_raddr = fifo_rdata;
                head_re    = 1'b1;
                head_raddr = fifo_rdata;
                state_next = ST_U_RD;
            end
            ST_U_RD: begin
                dist_u_next = node_rdata.best;
                node_we     = 1'b1;
                node_waddr  = u_reg;
                node_wdata  = '{best: node_rdata.best, cnt: node_rdata.cnt, mark: 1'b0};
                e_next      = head_valid_reg[u_reg] ? head_rdata : spfa_pkg::NIL_LINK;
                state_next  = ST_EDGE;
            end
            ST_EDGE: begin
                if (e_reg >= LW'(spfa_pkg::MAX_EDGES)) begin
                    state_next = ST_POP;
                end else begin
                    edge_re    = 1'b1;
                    state_next = ST_EDGE_W;
                end
            end
            ST_EDGE_W: begin
                v_next     = edge_rdata.target;
                cand_next  = dist_u_reg + {{(DW - spfa_pkg::COST_W){edge_rdata.cost[15]}},
                                           edge_rdata.cost};
                e_next     = edge_rdata.link;
                node_re    = 1'b1;
                node_raddr = edge_rdata.target;
                state_next = ST_RELAX;
            end
            ST_RELAX: begin
                state_next = ST_EDGE;
                if ($signed(cand_reg) < $signed(rec_v.best)) begin
                    node_we = 1'b1;
                    node_valid_next[v_reg] = 1'b1;
                    // a self loop lowers the distance used by the remaining edges
                    if (v_reg == u_reg) begin
                        dist_u_next = cand_reg;
                    end
                    if (!rec_v.mark) begin
                        node_wdata.cnt = cnt_new;
                        fifo_we   = 1'b1;
                        wr_next   = wr_reg + 1'b1;
                        fill_next = fill_reg + 1'b1;
                        if (cnt_new >= cycle_limit_reg) begin
                            state_next = ST_NEG;
                        end
                    end
                end
            end
            ST_NEG: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {1'b1, 1'b0, 32'd0, 6'd0};
                    m_last_next  = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_EMIT_RD: begin
                node_re    = 1'b1;
                state_next = ST_EMIT_LD;
            end
            ST_EMIT_LD: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    if (node_valid_reg[i_reg[NA-1:0]]) begin
                        m_data_next = {1'b0, node_rdata.best == spfa_pkg::INF_DIST,
                                       node_rdata.best, i_reg[NA-1:0]};
                    end else begin
                        m_data_next = {1'b0, 1'b1, spfa_pkg::INF_DIST, i_reg[NA-1:0]};
                    end
                    m_last_next = (i_reg == last_index);
                    if (i_reg == last_index) begin
                        state_next = ST_IDLE;
                    end else begin
                        i_next     = i_reg + 1'b1;
                        state_next = ST_EMIT_RD;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            head_valid_reg  <= '0;
            node_valid_reg  <= '0;
            edges_used_reg  <= '0;
            node_count_reg  <= CW'(64);
            cycle_limit_reg <= CW'(63);
            rd_reg          <= '0;
            wr_reg          <= '0;
            fill_reg        <= '0;
            i_reg           <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            head_valid_reg  <= head_valid_next;
            node_valid_reg  <= node_valid_next;
            edges_used_reg  <= edges_used_next;
            node_count_reg  <= node_count_next;
            cycle_limit_reg <= cycle_limit_next;
            rd_reg          <= rd_next;
            wr_reg          <= wr_next;
            fill_reg        <= fill_next;
            i_reg           <= i_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        from_reg   <= from_next;
        to_reg     <= to_next;
        cost_reg   <= cost_next;
        u_reg      <= u_next;
        v_reg      <= v_next;
        dist_u_reg <= dist_u_next;
        cand_reg   <= cand_next;
        e_reg      <= e_next;
        m_data_reg <= m_data_next;
        m_last_reg <= m_last_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

    // each vertex sits in the work queue at most once
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= FW'(MN))
        else $error("work queue overfilled");

    // a negative cycle report is a single, final transaction for vertex zero
    a_neg_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[39]) |-> (m_tlast && m_tdata[5:0] == '0))
        else $error("negative cycle result malformed");

    // the edge store never grows past its capacity
    a_edges_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        edges_used_reg <= LW'(spfa_pkg::MAX_EDGES))
        else $error("edge count beyond store");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

    typedef struct {
        logic [1:0]  act;
        logic [5:0]  tail;
        logic [5:0]  head;
        logic [15:0] weight;
        logic [5:0]  src;
    } graph_cmd_t;

    typedef struct {
        logic [5:0]  vertex;
        logic [31:0] dist_val;
        logic        unreach;
        logic        negcyc;
        logic        tl;
    } dist_report_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic        m_tlast;
    logic        cfg_we;
    logic        cfg_addr;
    logic [6:0]  cfg_wdata;

    graph_cmd_t   cmd_q[$];
    dist_report_t report_q[$];
    int           cmds_queued;
    int           cmds_taken;
    int           errors;
    int           send_gap;
    int           recv_stall;
    bit           calm;

    // predictor copy of the block state
    logic [6:0]  nodes_cfg;
    logic [6:0]  limit_cfg;
    int          adj_first[spfa_pkg::MAX_NODES];
    int          arc_to[spfa_pkg::MAX_EDGES];
    int          arc_cost[spfa_pkg::MAX_EDGES];
    int          arc_next[spfa_pkg::MAX_EDGES];
    int          arcs_used;
    int          path_len[spfa_pkg::MAX_NODES];

    spfa_shortest_path_neg_cycle_core u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic void wipe_graph();
        for (int i = 0; i < spfa_pkg::MAX_NODES; i++) adj_first[i] = spfa_pkg::MAX_EDGES;
        arcs_used = 0;
    endfunction

    // returns 1 when some vertex hits the enqueue limit
    function automatic bit relax_all(int src);
        bit         queued[spfa_pkg::MAX_NODES];
        logic [6:0] visits[spfa_pkg::MAX_NODES];
        int         work[$];
        int         u;
        int         e;
        int         v;
        int         cand;
        for (int i = 0; i < spfa_pkg::MAX_NODES; i++) begin
            path_len[i] = spfa_pkg::INF_DIST;
            queued[i] = 1'b0;
            visits[i] = '0;
        end
        path_len[src] = 0;
        visits[src] = 7'd1;
        queued[src] = 1'b1;
        work.push_back(src);
        while (work.size() > 0) begin
            u = work.pop_front();
            queued[u] = 1'b0;
            e = adj_first[u];
            while (e < spfa_pkg::MAX_EDGES) begin
                v = arc_to[e];
                cand = path_len[u] + arc_cost[e];
                if (cand < path_len[v]) begin
                    path_len[v] = cand;
                    if (!queued[v]) begin
                        queued[v] = 1'b1;
                        work.push_back(v);
                        visits[v] = visits[v] + 7'd1;
                        if (visits[v] >= limit_cfg) return 1'b1;
                    end
                end
                e = arc_next[e];
            end
        end
        return 1'b0;
    endfunction

    function automatic void predict(graph_cmd_t c);
        dist_report_t r;
        int n;
        case (c.act)
            spfa_pkg::ACT_CLEAR: wipe_graph();
            spfa_pkg::ACT_ADD: begin
                if (arcs_used < spfa_pkg::MAX_EDGES) begin
                    arc_to[arcs_used] = c.head;
                    arc_cost[arcs_used] = int'($signed(c.weight));
                    arc_next[arcs_used] = adj_first[c.tail];
                    adj_first[c.tail] = arcs_used;
                    arcs_used++;
                end
            end
            spfa_pkg::ACT_SOLVE: begin
                if (relax_all(c.src)) begin
                    r = '{6'd0, 32'd0, 1'b0, 1'b1, 1'b1};
                    report_q.push_back(r);
                end else begin
                    n = nodes_cfg;
                    if (n < 1) n = 1;
                    if (n > spfa_pkg::MAX_NODES) n = spfa_pkg::MAX_NODES;
                    for (int i = 0; i < n; i++) begin
                        r.vertex = i[5:0];
                        r.dist_val = path_len[i];
                        r.unreach = (path_len[i] == spfa_pkg::INF_DIST);
                        r.negcyc = 1'b0;
                        r.tl = (i + 1 == n);
                        report_q.push_back(r);
                    end
                end
            end
            default: ;
        endcase
    endfunction

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            send_gap <= 0;
        end else if (s_tvalid && !s_tready) begin
        end else if (send_gap > 0) begin
            s_tvalid <= 1'b0;
            send_gap <= send_gap - 1;
        end else if (cmd_q.size() > 0) begin
            graph_cmd_t c;
            c = cmd_q.pop_front();
            s_tvalid <= 1'b1;
            s_tuser <= c.act;
            s_tdata <= {6'd0, c.src, c.weight, c.head, c.tail};
            send_gap <= calm ? 0 : $urandom_range(0, 6);
        end else begin
            s_tvalid <= 1'b0;
        end
    end

    // input side transaction capture
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            graph_cmd_t c;
            c.act = s_tuser;
            c.tail = s_tdata[5:0];
            c.head = s_tdata[11:6];
            c.weight = s_tdata[27:12];
            c.src = s_tdata[33:28];
            predict(c);
            cmds_taken <= cmds_taken + 1;
        end
    end

    // result monitor and receiver stalls
    always @(posedge aclk) begin
        int stall;
        stall = recv_stall;
        if (aresetn && m_tvalid && m_tready) begin
            if (report_q.size() == 0) begin
                $display("%0t: unexpected result, got vertex %0d data %h last %b",
                         $time, m_tdata[5:0], m_tdata, m_tlast);
                errors++;
            end else begin
                dist_report_t r;
                r = report_q.pop_front();
                if (m_tdata[5:0] !== r.vertex) begin
                    $display("%0t: vertex exp %0d got %0d", $time, r.vertex, m_tdata[5:0]);
                    errors++;
                end
                if (m_tdata[37:6] !== r.dist_val) begin
                    $display("%0t: distance v%0d exp %h got %h", $time, r.vertex,
                             r.dist_val, m_tdata[37:6]);
                    errors++;
                end
                if (m_tdata[38] !== r.unreach) begin
                    $display("%0t: unreachable v%0d exp %b got %b", $time, r.vertex,
                             r.unreach, m_tdata[38]);
                    errors++;
                end
                if (m_tdata[39] !== r.negcyc) begin
                    $display("%0t: negative_cycle exp %b got %b", $time, r.negcyc,
                             m_tdata[39]);
                    errors++;
                end
                if (m_tlast !== r.tl) begin
                    $display("%0t: last v%0d exp %b got %b", $time, r.vertex, r.tl, m_tlast);
                    errors++;
                end
            end
            stall = calm ? 0 : $urandom_range(0, 6);
        end
        if (!aresetn) begin
            m_tready <= 1'b0;
            recv_stall <= 0;
        end else if (stall > 0) begin
            m_tready <= 1'b0;
            recv_stall <= stall - 1;
        end else begin
            m_tready <= 1'b1;
            recv_stall <= 0;
        end
    end

    task automatic write_reg(logic idx, logic [6:0] val);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == spfa_pkg::CFG_NODE_COUNT) nodes_cfg = val;
        else limit_cfg = val;
    endtask

    task automatic push_cmd(logic [1:0] act, logic [5:0] tail, logic [5:0] head,
                            logic [15:0] weight, logic [5:0] src);
        graph_cmd_t c;
        c = '{act, tail, head, weight, src};
        cmd_q.push_back(c);
        cmds_queued++;
    endtask

    task automatic drain();
        wait (cmds_taken == cmds_queued);
        wait (report_q.size() == 0);
        repeat (40) @(posedge aclk);
    endtask

    function automatic logic [15:0] pick_weight();
        int k;
        k = $urandom_range(0, 9);
        if (k < 7) return 16'($urandom_range(0, 1000));
        if (k < 9) return 16'(-$urandom_range(1, 40));
        return 16'($urandom);
    endfunction

    // random graph on the given vertices and arcs, then the given number of solves
    task automatic random_graph(int verts, int arcs, int solves);
        push_cmd(spfa_pkg::ACT_CLEAR, 6'($urandom), 6'($urandom), 16'($urandom),
                 6'($urandom));
        for (int i = 0; i < arcs; i++) begin
            if ($urandom_range(0, 19) == 0)
                push_cmd(spfa_pkg::ACT_UNUSED, 6'($urandom), 6'($urandom), 16'($urandom),
                         6'($urandom));
            push_cmd(spfa_pkg::ACT_ADD, 6'($urandom_range(0, verts - 1)),
                     6'($urandom_range(0, verts - 1)), pick_weight(), 6'($urandom));
        end
        for (int i = 0; i < solves; i++)
            push_cmd(spfa_pkg::ACT_SOLVE, 6'($urandom), 6'($urandom), 16'($urandom),
                     6'($urandom_range(0, verts - 1)));
    endtask

    initial begin
        #(20_000_000);
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        logic [6:0] nc_set[7];
        logic [6:0] lim_set[7];
        nc_set = '{7'd64, 7'd1, 7'd0, 7'd127, 7'd5, 7'd33, 7'd64};
        lim_set = '{7'd63, 7'd1, 7'd0, 7'd127, 7'd2, 7'd64, 7'd10};
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        m_tready = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = 1'b0;
        cfg_wdata = '0;
        cmds_queued = 0;
        cmds_taken = 0;
        errors = 0;
        send_gap = 0;
        recv_stall = 0;
        calm = 1'b0;
        nodes_cfg = 7'd64;
        limit_cfg = 7'd63;
        wipe_graph();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: extremes, unused action, unreached source, negative cycle
        push_cmd(spfa_pkg::ACT_UNUSED, 6'h3f, 6'h3f, 16'hffff, 6'h3f);
        push_cmd(spfa_pkg::ACT_SOLVE, 6'd0, 6'd0, 16'd0, 6'd0);
        push_cmd(spfa_pkg::ACT_CLEAR, 6'h3f, 6'h3f, 16'hffff, 6'h3f);
        push_cmd(spfa_pkg::ACT_ADD, 6'd0, 6'd63, 16'h7fff, 6'd0);
        push_cmd(spfa_pkg::ACT_ADD, 6'd63, 6'd1, 16'h8000, 6'd0);
        push_cmd(spfa_pkg::ACT_ADD, 6'd0, 6'd1, 16'd5, 6'd0);
        push_cmd(spfa_pkg::ACT_ADD, 6'd1, 6'd2, 16'hfffd, 6'd0);
        push_cmd(spfa_pkg::ACT_ADD, 6'd2, 6'd2, 16'd0, 6'd0);
        push_cmd(spfa_pkg::ACT_SOLVE, 6'd0, 6'd0, 16'd0, 6'd0);
        push_cmd(spfa_pkg::ACT_SOLVE, 6'd0, 6'd0, 16'd0, 6'd63);
        push_cmd(spfa_pkg::ACT_SOLVE, 6'd0, 6'd0, 16'd0, 6'd62);
        push_cmd(spfa_pkg::ACT_ADD, 6'd2, 6'd1, 16'hffff, 6'd0);
        push_cmd(spfa_pkg::ACT_SOLVE, 6'd0, 6'd0, 16'd0, 6'd0);
        push_cmd(spfa_pkg::ACT_CLEAR, 6'd0, 6'd0, 16'd0, 6'd0);
        push_cmd(spfa_pkg::ACT_SOLVE, 6'd0, 6'd0, 16'd0, 6'd5);
        drain();

        for (int p = 0; p < 7; p++) begin
            calm = ($urandom_range(0, 3) == 0);
            write_reg(spfa_pkg::CFG_NODE_COUNT, nc_set[p]);
            write_reg(spfa_pkg::CFG_CYCLE_LIMIT, lim_set[p]);
            for (int g = 0; g < 2; g++)
                random_graph($urandom_range(2, 12), $urandom_range(3, 9), 2);
            random_graph(64, 10, 1);
            drain();
        end

        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
